[sv/ipwl_pkg.sv]
// Shared constants, codes and chain token types for the IP and port whitelist match unit.
package ipwl_pkg;

    localparam int IP_RULES   = 16;
    localparam int PORT_RULES = 16;

    localparam int OP_W        = 2;
    localparam int INDEX_W     = 4;
    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int CAUSE_W     = 3;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [OP_W-1:0] OP_CHECK   = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_IP   = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_PORT = 2'd2;

    localparam logic [KIND_W-1:0] IP_KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] IP_KIND_MASK  = 2'd1;
    localparam logic [KIND_W-1:0] IP_KIND_RANGE = 2'd2;

    localparam logic [KIND_W-1:0] PORT_KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] PORT_KIND_RANGE = 2'd1;

    localparam logic [CAUSE_W-1:0] CAUSE_OFF        = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NO_RULES   = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_ADDR_MISS  = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_PORT_MISS  = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_ALL_MATCH  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IP_RULES       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_RULES     = 2'd2;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } ip_tok_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [PORT_W-1:0] port;
    } port_tok_t;

endpackage

[sv/ipwl_ip_cell.sv]
// One address rule slot: holds its rule and tests the passing address token against it.
module ipwl_ip_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [ipwl_pkg::KIND_W-1:0] wr_kind,
    input  logic [ipwl_pkg::ADDR_W-1:0] wr_base,
    input  logic [ipwl_pkg::ADDR_W-1:0] wr_extra,
    input  logic                        active,
    input  ipwl_pkg::ip_tok_t           tok_in,
    output ipwl_pkg::ip_tok_t           tok_out
);

    logic [ipwl_pkg::KIND_W-1:0] kind_reg;
    logic [ipwl_pkg::ADDR_W-1:0] base_reg;
    logic [ipwl_pkg::ADDR_W-1:0] extra_reg;
    logic                        match;
    ipwl_pkg::ip_tok_t           tok_next;
    ipwl_pkg::ip_tok_t           tok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            kind_reg  <= wr_kind;
            base_reg  <= wr_base;
            extra_reg <= wr_extra;
        end
    end

    always_comb begin
        unique case (kind_reg)
            ipwl_pkg::IP_KIND_EXACT: match = (tok_in.addr == base_reg);
            ipwl_pkg::IP_KIND_MASK:  match = ((tok_in.addr & extra_reg) == (base_reg & extra_reg));
            ipwl_pkg::IP_KIND_RANGE: match = (tok_in.addr >= base_reg) && (tok_in.addr <= extra_reg);
            default:                 match = 1'b0;
        endcase
    end

    always_comb begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | (active & match);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.hit  <= tok_next.hit;
        tok_reg.addr <= tok_next.addr;
    end

    assign tok_out = tok_reg;

endmodule

[sv/ipwl_port_cell.sv]
// One port rule slot: holds its rule and tests the passing port token against it.
module ipwl_port_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [ipwl_pkg::KIND_W-1:0] wr_kind,
    input  logic [ipwl_pkg::PORT_W-1:0] wr_low,
    input  logic [ipwl_pkg::PORT_W-1:0] wr_high,
    input  logic                        active,
    input  ipwl_pkg::port_tok_t         tok_in,
    output ipwl_pkg::port_tok_t         tok_out
);

    logic [ipwl_pkg::KIND_W-1:0] kind_reg;
    logic [ipwl_pkg::PORT_W-1:0] low_reg;
    logic [ipwl_pkg::PORT_W-1:0] high_reg;
    logic                        match;
    ipwl_pkg::port_tok_t         tok_next;
    ipwl_pkg::port_tok_t         tok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            kind_reg <= wr_kind;
            low_reg  <= wr_low;
            high_reg <= wr_high;
        end
    end

    always_comb begin
        unique case (kind_reg)
            ipwl_pkg::PORT_KIND_EXACT: match = (tok_in.port == low_reg);
            ipwl_pkg::PORT_KIND_RANGE: match = (tok_in.port >= low_reg) && (tok_in.port <= high_reg);
            default:                   match = 1'b0;
        endcase
    end

    always_comb begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | (active & match);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.hit  <= tok_next.hit;
        tok_reg.port <= tok_next.port;
    end

    assign tok_out = tok_reg;

endmodule

[sv/ip_port_whitelist_match_unit.sv]
// Top level of the IP and port whitelist match unit: register file, cell chains and verdict.
//
// Every address rule and every port rule lives in a cell of its own; the cells of each kind
// form a chain, and a check request travels down both chains side by side, one cell per clock,
// collecting a hit flag. A check's verdict is offered on the result channel once its tokens
// have left the longer chain and the verdict has been formed and registered. The unit works
// on one check at a time and accepts no request while a check is in the chains.
// A verdict waiting on the result channel does not block write requests or the next check;
// only when a second verdict is ready while the first still waits does the input stall.
// Configuration writes are accepted in every cycle and should be issued only while idle.
module ip_port_whitelist_match_unit (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ipwl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ipwl_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ipwl_pkg::OP_W-1:0]        s_op,
    input  logic [ipwl_pkg::INDEX_W-1:0]     s_rule_index,
    input  logic [ipwl_pkg::KIND_W-1:0]      s_ip_rule_kind,
    input  logic [ipwl_pkg::ADDR_W-1:0]      s_rule_address,
    input  logic [ipwl_pkg::ADDR_W-1:0]      s_rule_mask_or_end,
    input  logic [ipwl_pkg::KIND_W-1:0]      s_port_rule_kind,
    input  logic [ipwl_pkg::PORT_W-1:0]      s_port_first,
    input  logic [ipwl_pkg::PORT_W-1:0]      s_port_last,
    input  logic [ipwl_pkg::ADDR_W-1:0]      s_client_address,
    input  logic [ipwl_pkg::PORT_W-1:0]      s_client_port_number,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_allowed,
    output logic [ipwl_pkg::CAUSE_W-1:0]     m_cause
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    logic                           filter_enabled_reg;
    logic [ipwl_pkg::COUNT_W-1:0]   ip_rules_in_use_reg;
    logic [ipwl_pkg::COUNT_W-1:0]   port_rules_in_use_reg;

    state_t                         state_reg, state_next;
    logic                           ip_done_reg, ip_done_next;
    logic                           port_done_reg, port_done_next;
    logic                           ip_hit_reg, ip_hit_next;
    logic                           port_hit_reg, port_hit_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_allowed_reg, m_allowed_next;
    logic [ipwl_pkg::CAUSE_W-1:0]   m_cause_reg, m_cause_next;

    logic                           req_accept;
    logic                           check_accept;
    logic                           verdict_allowed;
    logic [ipwl_pkg::CAUSE_W-1:0]   verdict_cause;
    logic                           ip_any_hit;
    logic                           port_any_hit;

    ipwl_pkg::ip_tok_t              ip_tok   [ipwl_pkg::IP_RULES+1];
    ipwl_pkg::port_tok_t            port_tok [ipwl_pkg::PORT_RULES+1];
    logic [ipwl_pkg::IP_RULES-1:0]   ip_wr_en;
    logic [ipwl_pkg::IP_RULES-1:0]   ip_active;
    logic [ipwl_pkg::PORT_RULES-1:0] port_wr_en;
    logic [ipwl_pkg::PORT_RULES-1:0] port_active;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_enabled_reg    <= 1'b0;
            ip_rules_in_use_reg   <= '0;
            port_rules_in_use_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ipwl_pkg::CFG_FILTER_ENABLED: filter_enabled_reg    <= cfg_data[0];
                ipwl_pkg::CFG_IP_RULES:       ip_rules_in_use_reg   <= cfg_data;
                ipwl_pkg::CFG_PORT_RULES:     port_rules_in_use_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign req_accept   = s_valid && s_ready;
    assign check_accept = req_accept && (s_op == ipwl_pkg::OP_CHECK);

    // A check request enters both chains with a cleared hit flag.
    assign ip_tok[0].valid   = check_accept;
    assign ip_tok[0].hit     = 1'b0;
    assign ip_tok[0].addr    = s_client_address;
    assign port_tok[0].valid = check_accept;
    assign port_tok[0].hit   = 1'b0;
    assign port_tok[0].port  = s_client_port_number;

    for (genvar g = 0; g < ipwl_pkg::IP_RULES; g++) begin : g_ip
        assign ip_wr_en[g]  = req_accept && (s_op == ipwl_pkg::OP_WR_IP)
                              && (32'(s_rule_index) == g);
        // Slots at or beyond the rule count never contribute a hit.
        assign ip_active[g] = (32'(ip_rules_in_use_reg) > g);

        ipwl_ip_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (ip_wr_en[g]),
            .wr_kind  (s_ip_rule_kind),
            .wr_base  (s_rule_address),
            .wr_extra (s_rule_mask_or_end),
            .active   (ip_active[g]),
            .tok_in   (ip_tok[g]),
            .tok_out  (ip_tok[g+1])
        );
    end

    for (genvar g = 0; g < ipwl_pkg::PORT_RULES; g++) begin : g_port
        assign port_wr_en[g]  = req_accept && (s_op == ipwl_pkg::OP_WR_PORT)
                                && (32'(s_rule_index) == g);
        assign port_active[g] = (32'(port_rules_in_use_reg) > g);

        ipwl_port_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (port_wr_en[g]),
            .wr_kind  (s_port_rule_kind),
            .wr_low   (s_port_first),
            .wr_high  (s_port_last),
            .active   (port_active[g]),
            .tok_in   (port_tok[g]),
            .tok_out  (port_tok[g+1])
        );
    end

    // Verdict from the collected hit flags.
    always_comb begin
        ip_any_hit   = (ip_rules_in_use_reg == '0) || ip_hit_reg;
        port_any_hit = (port_rules_in_use_reg == '0) || port_hit_reg;
        if (!filter_enabled_reg) begin
            verdict_allowed = 1'b1;
            verdict_cause   = ipwl_pkg::CAUSE_OFF;
        end else if ((ip_rules_in_use_reg == '0) && (port_rules_in_use_reg == '0)) begin
            verdict_allowed = 1'b0;
            verdict_cause   = ipwl_pkg::CAUSE_NO_RULES;
        end else if (!ip_any_hit) begin
            verdict_allowed = 1'b0;
            verdict_cause   = ipwl_pkg::CAUSE_ADDR_MISS;
        end else if (!port_any_hit) begin
            verdict_allowed = 1'b0;
            verdict_cause   = ipwl_pkg::CAUSE_PORT_MISS;
        end else begin
            verdict_allowed = 1'b1;
            verdict_cause   = ipwl_pkg::CAUSE_ALL_MATCH;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ip_done_next   = ip_done_reg;
        port_done_next = port_done_reg;
        ip_hit_next    = ip_hit_reg;
        port_hit_next  = port_hit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_allowed_next = m_allowed_reg;
        m_cause_next   = m_cause_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (check_accept) begin
                    state_next     = ST_RUN;
                    ip_done_next   = 1'b0;
                    port_done_next = 1'b0;
                end
            end
            ST_RUN: begin
                if (ip_tok[ipwl_pkg::IP_RULES].valid) begin
                    ip_done_next = 1'b1;
                    ip_hit_next  = ip_tok[ipwl_pkg::IP_RULES].hit;
                end
                if (port_tok[ipwl_pkg::PORT_RULES].valid) begin
                    port_done_next = 1'b1;
                    port_hit_next  = port_tok[ipwl_pkg::PORT_RULES].hit;
                end
                if (ip_done_next && port_done_next) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold the verdict until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_allowed_next = verdict_allowed;
                    m_cause_next   = verdict_cause;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ip_done_reg   <= 1'b0;
            port_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ip_done_reg   <= ip_done_next;
            port_done_reg <= port_done_next;
            m_valid_reg   <= m_valid_next;
        end
        ip_hit_reg    <= ip_hit_next;
        port_hit_reg  <= port_hit_next;
        m_allowed_reg <= m_allowed_next;
        m_cause_reg   <= m_cause_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_allowed = m_allowed_reg;
    assign m_cause   = m_cause_reg;

`ifndef NO_ASSERTIONS
    a_launch_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        check_accept |=> (state_reg == ST_RUN))
        else $error("check request did not start a chain walk");

    a_ip_end_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ip_tok[ipwl_pkg::IP_RULES].valid |-> (state_reg == ST_RUN))
        else $error("address chain finished outside of a check");

    a_port_end_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        port_tok[ipwl_pkg::PORT_RULES].valid |-> (state_reg == ST_RUN))
        else $error("port chain finished outside of a check");

    a_verdict_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_allowed == ((m_cause == ipwl_pkg::CAUSE_OFF)
                                   || (m_cause == ipwl_pkg::CAUSE_ALL_MATCH))))
        else $error("allowed flag disagrees with cause");
`endif

endmodule

[tb/ip_port_whitelist_match_unit_tb.sv]
// Self-checking testbench for the IP and port whitelist match unit.
module ip_port_whitelist_match_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipwl_pkg::*;

    localparam int IDLE_PCT       = 9;
    localparam int DRAIN_CYCLES   = 30;
    localparam int STALL_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [OP_W-1:0]        OP_UNUSED       = 2'd3;
    localparam logic [KIND_W-1:0]      IP_KIND_NONE    = 2'd3;
    localparam logic [KIND_W-1:0]      PORT_KIND_NONE  = 2'd2;
    localparam logic [KIND_W-1:0]      PORT_KIND_SPARE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED      = 2'd3;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] slot;
        logic [KIND_W-1:0]  ip_kind;
        logic [ADDR_W-1:0]  rule_address;
        logic [ADDR_W-1:0]  rule_mask_or_end;
        logic [KIND_W-1:0]  port_kind;
        logic [PORT_W-1:0]  port_first;
        logic [PORT_W-1:0]  port_last;
        logic [ADDR_W-1:0]  client_address;
        logic [PORT_W-1:0]  peer_port;
    } acl_request_t;

    typedef struct {
        logic               allowed;
        logic [CAUSE_W-1:0] cause;
    } verdict_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic               s_valid              = 1'b0;
    logic               s_ready;
    logic [OP_W-1:0]    s_op                 = '0;
    logic [INDEX_W-1:0] s_rule_index         = '0;
    logic [KIND_W-1:0]  s_ip_rule_kind       = '0;
    logic [ADDR_W-1:0]  s_rule_address       = '0;
    logic [ADDR_W-1:0]  s_rule_mask_or_end   = '0;
    logic [KIND_W-1:0]  s_port_rule_kind     = '0;
    logic [PORT_W-1:0]  s_port_first         = '0;
    logic [PORT_W-1:0]  s_port_last          = '0;
    logic [ADDR_W-1:0]  s_client_address     = '0;
    logic [PORT_W-1:0]  s_client_port_number = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_allowed;
    logic [CAUSE_W-1:0] m_cause;

    // Shadow copy of the rule tables and registers.
    logic [KIND_W-1:0]  ip_kind_tab   [IP_RULES];
    logic [ADDR_W-1:0]  ip_base_tab   [IP_RULES];
    logic [ADDR_W-1:0]  ip_extra_tab  [IP_RULES];
    logic [KIND_W-1:0]  port_kind_tab [PORT_RULES];
    logic [PORT_W-1:0]  port_low_tab  [PORT_RULES];
    logic [PORT_W-1:0]  port_high_tab [PORT_RULES];
    logic               filter_on     = 1'b0;
    logic [COUNT_W-1:0] ip_rule_count   = '0;
    logic [COUNT_W-1:0] port_rule_count = '0;

    verdict_t verdict_queue[$];
    int       error_count  = 0;
    int       idle_cycles  = 0;
    logic     quiet_mode   = 1'b0;
    int       stall_pending = 0;
    int       stall_served  = 0;
    int       stall_left    = 0;

    ip_port_whitelist_match_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_op                 (s_op),
        .s_rule_index         (s_rule_index),
        .s_ip_rule_kind       (s_ip_rule_kind),
        .s_rule_address       (s_rule_address),
        .s_rule_mask_or_end   (s_rule_mask_or_end),
        .s_port_rule_kind     (s_port_rule_kind),
        .s_port_first         (s_port_first),
        .s_port_last          (s_port_last),
        .s_client_address     (s_client_address),
        .s_client_port_number (s_client_port_number),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_allowed            (m_allowed),
        .m_cause              (m_cause)
    );

    always #6 aclk = ~aclk;

    function automatic logic address_hits(input logic [ADDR_W-1:0] a, input int i);
        case (ip_kind_tab[i])
            IP_KIND_EXACT: return a == ip_base_tab[i];
            IP_KIND_MASK:  return (a & ip_extra_tab[i]) == (ip_base_tab[i] & ip_extra_tab[i]);
            IP_KIND_RANGE: return a >= ip_base_tab[i] && a <= ip_extra_tab[i];
            default:       return 1'b0;
        endcase
    endfunction

    function automatic logic port_hits(input logic [PORT_W-1:0] p, input int i);
        case (port_kind_tab[i])
            PORT_KIND_EXACT: return p == port_low_tab[i];
            PORT_KIND_RANGE: return p >= port_low_tab[i] && p <= port_high_tab[i];
            default:         return 1'b0;
        endcase
    endfunction

    function automatic verdict_t judge_connection(input logic [ADDR_W-1:0] a,
                                                  input logic [PORT_W-1:0] p);
        verdict_t v;
        int       nip;
        int       nport;
        int       i;
        logic     hit;
        nip   = (ip_rule_count > IP_RULES) ? IP_RULES : ip_rule_count;
        nport = (port_rule_count > PORT_RULES) ? PORT_RULES : port_rule_count;
        v.allowed = 1'b1;
        v.cause   = CAUSE_ALL_MATCH;
        if (!filter_on) begin
            v.cause = CAUSE_OFF;
        end else if (nip == 0 && nport == 0) begin
            v.allowed = 1'b0;
            v.cause   = CAUSE_NO_RULES;
        end else begin
            hit = (nip == 0);
            for (i = 0; i < nip; i++)
                if (address_hits(a, i)) hit = 1'b1;
            if (!hit) begin
                v.allowed = 1'b0;
                v.cause   = CAUSE_ADDR_MISS;
            end else begin
                hit = (nport == 0);
                for (i = 0; i < nport; i++)
                    if (port_hits(p, i)) hit = 1'b1;
                if (!hit) begin
                    v.allowed = 1'b0;
                    v.cause   = CAUSE_PORT_MISS;
                end
            end
        end
        return v;
    endfunction

    // Updates the shadow tables or queues a verdict for an accepted request.
    function automatic void record_request(input acl_request_t r);
        case (r.op)
            OP_WR_IP: begin
                ip_kind_tab[r.slot]  = r.ip_kind;
                ip_base_tab[r.slot]  = r.rule_address;
                ip_extra_tab[r.slot] = r.rule_mask_or_end;
            end
            OP_WR_PORT: begin
                port_kind_tab[r.slot] = r.port_kind;
                port_low_tab[r.slot]  = r.port_first;
                port_high_tab[r.slot] = r.port_last;
            end
            OP_CHECK: verdict_queue.push_back(judge_connection(r.client_address, r.peer_port));
            default: ;
        endcase
    endfunction

    function automatic acl_request_t noise_request(input logic [OP_W-1:0] op);
        acl_request_t r;
        r.op               = op;
        r.slot             = INDEX_W'($urandom_range(15));
        r.ip_kind          = KIND_W'($urandom_range(3));
        r.rule_address     = $urandom;
        r.rule_mask_or_end = $urandom;
        r.port_kind        = KIND_W'($urandom_range(3));
        r.port_first       = PORT_W'($urandom);
        r.port_last        = PORT_W'($urandom);
        r.client_address   = $urandom;
        r.peer_port        = PORT_W'($urandom);
        return r;
    endfunction

    function automatic acl_request_t random_ip_rule();
        acl_request_t r;
        r = noise_request(OP_WR_IP);
        // Cluster about half of the bases in one subnet so that checks find them.
        if ($urandom_range(1))
            r.rule_address = 32'h0A00_0000 | ADDR_W'($urandom_range(255));
        if (r.ip_kind == IP_KIND_MASK && $urandom_range(3) != 0)
            r.rule_mask_or_end = 32'hFFFF_FFFF << $urandom_range(32);
        if (r.ip_kind == IP_KIND_RANGE && $urandom_range(3) != 0)
            r.rule_mask_or_end = r.rule_address + ADDR_W'($urandom_range(1000));
        return r;
    endfunction

    function automatic acl_request_t random_port_rule();
        acl_request_t r;
        r = noise_request(OP_WR_PORT);
        case ($urandom_range(3))
            0: r.port_first = '0;
            1: r.port_first = '1;
            2: r.port_first = PORT_W'(80 + $urandom_range(20));
            default: ;
        endcase
        if ($urandom_range(9) < 7)
            r.port_last = r.port_first + PORT_W'($urandom_range(300));
        return r;
    endfunction

    // Checks mostly aim at or next to a stored rule; the rest are random.
    function automatic acl_request_t random_check();
        acl_request_t r;
        int           s;
        r = noise_request(OP_CHECK);
        s = $urandom_range(IP_RULES - 1);
        case ($urandom_range(4))
            0: r.client_address = ip_base_tab[s];
            1: r.client_address = ip_extra_tab[s];
            2: r.client_address = ip_base_tab[s] + ADDR_W'($urandom_range(3));
            3: r.client_address = ip_base_tab[s] ^ (32'h1 << $urandom_range(31));
            default: ;
        endcase
        s = $urandom_range(PORT_RULES - 1);
        case ($urandom_range(4))
            0: r.peer_port = port_low_tab[s];
            1: r.peer_port = port_high_tab[s];
            2: r.peer_port = port_low_tab[s] + PORT_W'(1);
            3: r.peer_port = port_high_tab[s] - PORT_W'(1);
            default: ;
        endcase
        return r;
    endfunction

    function automatic acl_request_t random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return random_check();
        else if (pick < 78)
            return random_ip_rule();
        else if (pick < 95)
            return random_port_rule();
        return noise_request(OP_UNUSED);
    endfunction

    task automatic send_request(input acl_request_t r);
        int gap;
        gap = 0;
        while (!quiet_mode && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_op                 <= r.op;
        s_rule_index         <= r.slot;
        s_ip_rule_kind       <= r.ip_kind;
        s_rule_address       <= r.rule_address;
        s_rule_mask_or_end   <= r.rule_mask_or_end;
        s_port_rule_kind     <= r.port_kind;
        s_port_first         <= r.port_first;
        s_port_last          <= r.port_last;
        s_client_address     <= r.client_address;
        s_client_port_number <= r.peer_port;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        record_request(r);
    endtask

    task automatic send_ip_rule(input int slot, input logic [KIND_W-1:0] kind,
                                input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] extra);
        acl_request_t r;
        r = noise_request(OP_WR_IP);
        r.slot             = INDEX_W'(slot);
        r.ip_kind          = kind;
        r.rule_address     = base;
        r.rule_mask_or_end = extra;
        send_request(r);
    endtask

    task automatic send_port_rule(input int slot, input logic [KIND_W-1:0] kind,
                                  input logic [PORT_W-1:0] lo, input logic [PORT_W-1:0] hi);
        acl_request_t r;
        r = noise_request(OP_WR_PORT);
        r.slot       = INDEX_W'(slot);
        r.port_kind  = kind;
        r.port_first = lo;
        r.port_last  = hi;
        send_request(r);
    endtask

    task automatic send_check(input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p);
        acl_request_t r;
        r = noise_request(OP_CHECK);
        r.client_address = a;
        r.peer_port      = p;
        send_request(r);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_FILTER_ENABLED: filter_on       = data[0];
            CFG_IP_RULES:       ip_rule_count   = data;
            CFG_PORT_RULES:     port_rule_count = data;
            default: ;
        endcase
    endtask

    // Write requests give no verdict, so the task also waits out a drain period after the verdicts are in.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (verdict_queue.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure_filter(input logic [CFG_DATA_W-1:0] enable,
                                    input logic [CFG_DATA_W-1:0] ip_total,
                                    input logic [CFG_DATA_W-1:0] port_total);
        wait_idle();
        write_register(CFG_FILTER_ENABLED, enable);
        write_register(CFG_IP_RULES, ip_total);
        write_register(CFG_PORT_RULES, port_total);
        cfg_valid <= 1'b0;
    endtask

    // After reset the filter is off, so the empty tables are never consulted.
    task automatic test_reset_defaults();
        send_check('0, '0);
        send_check('1, '1);
        send_request(noise_request(OP_UNUSED));
        wait_idle();
        write_register(CFG_UNUSED, CFG_DATA_W'($urandom_range(31)));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_rule_deny();
        configure_filter(5'd1, 5'd0, 5'd0);
        send_check(32'hC0A8_0001, 16'd443);
    endtask

    task automatic test_rule_kinds();
        send_ip_rule(0, IP_KIND_EXACT, 32'hC0A8_0001, '0);
        send_ip_rule(1, IP_KIND_MASK, 32'h0A00_0000, 32'hFF00_0000);
        send_ip_rule(2, IP_KIND_RANGE, 32'h7F00_0000, 32'h7F00_00FF);
        // A range whose end lies below its start matches nothing.
        send_ip_rule(3, IP_KIND_RANGE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_ip_rule(4, IP_KIND_NONE, '0, '1);
        send_port_rule(0, PORT_KIND_EXACT, 16'hFFFF, '0);
        send_port_rule(1, PORT_KIND_RANGE, 16'd1000, 16'd2000);
        send_port_rule(2, PORT_KIND_NONE, '0, '1);
        send_port_rule(3, PORT_KIND_RANGE, 16'd500, 16'd100);
        send_port_rule(4, PORT_KIND_SPARE, '0, '1);
        configure_filter(5'd1, 5'd5, 5'd5);
        send_check(32'hC0A8_0001, 16'hFFFF);
        send_check(32'h0A12_3456, 16'd1500);
        send_check(32'h7F00_00FF, 16'd1000);
        send_check(32'h7F00_0100, 16'd1000);
        send_check(32'h0000_0000, 16'd0);
        send_check(32'hC0A8_0001, 16'd999);
        configure_filter(5'd1, 5'd0, 5'd5);
        send_check(32'h1234_5678, 16'd2000);
        configure_filter(5'd1, 5'd5, 5'd0);
        send_check(32'h0A00_0000, 16'd7);
    endtask

    task automatic test_random_traffic();
        acl_request_t r;
        int           slot;
        int           phase;
        // Every slot gets a rule first, so no check ever reads an unwritten entry.
        for (slot = 0; slot < IP_RULES; slot++) begin
            r = random_ip_rule();
            r.slot = INDEX_W'(slot);
            send_request(r);
        end
        for (slot = 0; slot < PORT_RULES; slot++) begin
            r = random_port_rule();
            r.slot = INDEX_W'(slot);
            send_request(r);
        end
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure_filter(5'd1, 5'd16, 5'd16);
                1: configure_filter(5'd1, 5'd1, 5'd1);
                2: configure_filter(5'd1, 5'd0, 5'd16);
                3: configure_filter(5'd1, 5'd16, 5'd0);
                // Only bit 0 of the enable counts, and counts above the depth saturate.
                4: configure_filter(5'd31, 5'd31, 5'd17);
                5: configure_filter(5'd2, 5'd8, 5'd8);
                6: configure_filter(5'd1, 5'd0, 5'd0);
                default: configure_filter(CFG_DATA_W'($urandom_range(31)),
                                          CFG_DATA_W'($urandom_range(31)),
                                          CFG_DATA_W'($urandom_range(31)));
            endcase
            quiet_mode = (phase == 1);
            repeat (45) send_request(random_request());
        end
        quiet_mode = 1'b0;
    endtask

    // The receiver stalls while checks keep coming, so the unit fills and backs up.
    task automatic test_output_backpressure();
        configure_filter(5'd1, 5'd16, 5'd16);
        quiet_mode = 1'b1;
        stall_pending++;
        repeat (20) send_request(random_check());
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_empty_rule_deny();
        test_rule_kinds();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_queue.size() == 0) begin
                $display("%0t: verdict with no request pending, allowed %0b cause %0d",
                         $time, m_allowed, m_cause);
                error_count++;
            end else begin
                want = verdict_queue.pop_front();
                if (m_allowed !== want.allowed) begin
                    $display("%0t: allowed mismatch, expected %0b, actual %0b",
                             $time, want.allowed, m_allowed);
                    error_count++;
                end
                if (m_cause !== want.cause) begin
                    $display("%0t: cause mismatch, expected %0d, actual %0d",
                             $time, want.cause, m_cause);
                    error_count++;
                end
            end
        end
        if (stall_served != stall_pending) begin
            stall_served++;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

[sim.f]
sv/ipwl_pkg.sv
sv/ipwl_ip_cell.sv
sv/ipwl_port_cell.sv
sv/ip_port_whitelist_match_unit.sv
tb/ip_port_whitelist_match_unit_tb.sv
